// ----- src/pngu_pkg.sv -----
// Shared types, register map and filter arithmetic for the PNG scanline unfilter.
// Depends on nothing; used by png_scanline_unfilter_top.

package pngu_pkg;

   // Default sizing of the line store and the left-neighbor history
   localparam int LINE_BYTES_MAX_DEF  = 8192;
   localparam int PIXEL_BYTES_MAX_DEF = 8;

   // Register map: one 32-bit register per word, index taken from paddr[2]
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_BPP      = 1'b0;
   localparam logic CSR_IDX_ROW_BYTES = 1'b1;

   // Filter type codes carried in the first byte of each row
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type_type;

   localparam logic [7:0] FILT_LAST_CODE = 8'd4;

   // Paeth predictor: pick the neighbor closest to a + b - c, ties to a, then b
   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] sa;
      logic signed [9:0] sb;
      logic signed [9:0] sc;
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [9:0] pa;
      logic [9:0] pb;
      logic [9:0] pc;
      logic [7:0] pick;
      sa = signed'({2'b00, a});
      sb = signed'({2'b00, b});
      sc = signed'({2'b00, c});
      // p - a = b - c, p - b = a - c, p - c = a + b - 2c
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      pa = (da < 0) ? 10'(-da) : 10'(da);
      pb = (db < 0) ? 10'(-db) : 10'(db);
      pc = (dc < 0) ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

// ----- src/png_scanline_unfilter_top.sv -----
// PNG scanline filter reconstruction: row tracking, line store and filter datapath.
// Depends on pngu_pkg for register map, filter codes and the Paeth predictor.
//
// Takes one byte of the decompressed stream per beat and returns one reconstructed
// byte per data byte, plus an error beat for a filter-type byte above four; a valid
// filter-type byte returns nothing. One byte per clock is sustained while rsp_stall is
// low; a result passes stage 1, with its registered read of the single-port-read line
// store that holds the row above, and then the output register. The line store is not
// cleared after reset: the first row of every frame ignores it, and each entry is
// written before a later row reads it. Program bytes_per_pixel and row_bytes only
// while the block is idle.

module png_scanline_unfilter_top #(
   parameter int LINE_BYTES_MAX  = pngu_pkg::LINE_BYTES_MAX_DEF,
   parameter int PIXEL_BYTES_MAX = pngu_pkg::PIXEL_BYTES_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_frame_start,
   // result stream
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_pixel_byte,
   output logic                            rsp_row_end,
   output logic                            rsp_filter_error,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pngu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int CNT_W  = $clog2(LINE_BYTES_MAX + 1);
   localparam int ADDR_W = $clog2(LINE_BYTES_MAX);
   localparam int HIST_W = (PIXEL_BYTES_MAX > 1) ? $clog2(PIXEL_BYTES_MAX) : 1;

   // ---------------------------------------------------------------- registers
   logic [3:0]  bpp_ff;
   logic [13:0] row_bytes_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   // Write configuration on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= 4'd1;
         row_bytes_ff <= 14'd1;
      end else if (csr_wr) begin
         if (paddr[2] == pngu_pkg::CSR_IDX_BPP) begin
            bpp_ff <= pwdata[3:0];
         end else begin
            row_bytes_ff <= pwdata[13:0];
         end
      end
   end

   // Read back the selected register
   always_comb begin
      if (paddr[2] == pngu_pkg::CSR_IDX_ROW_BYTES) begin
         prdata = {18'd0, row_bytes_ff};
      end else begin
         prdata = {28'd0, bpp_ff};
      end
   end

   // Clamp register values into their working range
   logic [3:0]  bpp_eff;
   logic [31:0] rb_eff;

   always_comb begin
      if (bpp_ff == 4'd0) begin
         bpp_eff = 4'd1;
      end else if (32'(bpp_ff) > 32'(PIXEL_BYTES_MAX)) begin
         bpp_eff = 4'(PIXEL_BYTES_MAX);
      end else begin
         bpp_eff = bpp_ff;
      end
      if (row_bytes_ff == 14'd0) begin
         rb_eff = 32'd1;
      end else if (32'(row_bytes_ff) > 32'(LINE_BYTES_MAX)) begin
         rb_eff = 32'(LINE_BYTES_MAX);
      end else begin
         rb_eff = 32'(row_bytes_ff);
      end
   end

   // ---------------------------------------------------------------- flow control
   logic s1_valid_ff;
   logic out_valid_ff;
   logic s1_advance;
   logic req_accept;

   assign s1_advance = ~out_valid_ff | ~rsp_stall;
   assign req_stall  = s1_valid_ff & ~s1_advance;
   assign req_accept = req_valid & ~req_stall;

   // ---------------------------------------------------------------- row tracking
   logic [CNT_W-1:0]          col_ff, col_in;
   pngu_pkg::filter_type_type filter_ff, filter_in;
   logic                      first_ff, first_in;
   logic                      err_ff, err_in;

   logic [CNT_W-1:0] col_eff;
   logic             first_eff;
   logic [ADDR_W-1:0] idx;
   logic             is_filter_byte;
   logic             bad_filter;
   logic             last;
   logic             has_left;
   logic             s1_load;

   always_comb begin
      // A frame start abandons the current row and opens the first row
      col_eff        = req_frame_start ? '0 : col_ff;
      first_eff      = req_frame_start | first_ff;
      is_filter_byte = (col_eff == '0);
      bad_filter     = req_data_byte > pngu_pkg::FILT_LAST_CODE;
      idx            = ADDR_W'(col_eff - CNT_W'(1));
      last           = (32'(idx) + 32'd1) >= rb_eff;
      has_left       = 32'(idx) >= 32'(bpp_eff);

      col_in    = col_ff;
      filter_in = filter_ff;
      first_in  = first_ff;
      err_in    = err_ff;
      if (req_accept) begin
         first_in = first_eff;
         if (is_filter_byte) begin
            col_in = CNT_W'(1);
            if (bad_filter) begin
               filter_in = pngu_pkg::FILT_NONE;
               err_in    = 1'b1;
            end else begin
               filter_in = pngu_pkg::filter_type_type'(req_data_byte[2:0]);
               err_in    = 1'b0;
            end
         end else if (last) begin
            col_in   = '0;
            first_in = 1'b0;
         end else begin
            col_in = CNT_W'(32'(idx) + 32'd2);
         end
      end
      s1_load = req_accept & (~is_filter_byte | bad_filter);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         filter_ff <= pngu_pkg::FILT_NONE;
         first_ff  <= 1'b1;
         err_ff    <= 1'b0;
      end else begin
         col_ff    <= col_in;
         filter_ff <= filter_in;
         first_ff  <= first_in;
         err_ff    <= err_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic                      s1_valid_in;
   logic                      s1_report_ff;
   logic [7:0]                s1_byte_ff;
   logic [ADDR_W-1:0]         s1_idx_ff;
   pngu_pkg::filter_type_type s1_filter_ff;
   logic                      s1_err_ff;
   logic                      s1_first_ff;
   logic                      s1_last_ff;
   logic                      s1_left_ff;

   always_comb begin
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Hold the beat's context while the line store read is in flight
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_report_ff <= is_filter_byte;
         s1_byte_ff   <= req_data_byte;
         s1_idx_ff    <= idx;
         s1_filter_ff <= filter_ff;
         s1_err_ff    <= err_ff;
         s1_first_ff  <= first_eff;
         s1_last_ff   <= last;
         s1_left_ff   <= has_left;
      end
   end

   // ---------------------------------------------------------------- line store
   logic [7:0] line_mem [LINE_BYTES_MAX];
   logic [7:0] above_rd_ff;
   logic       mem_we;
   logic [7:0] res;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[s1_idx_ff] <= res;
      end
      if (s1_load) begin
         above_rd_ff <= line_mem[idx];
      end
   end

   // ---------------------------------------------------------------- filter datapath
   logic [7:0] left_hist_ff   [PIXEL_BYTES_MAX];
   logic [7:0] upleft_hist_ff [PIXEL_BYTES_MAX];
   logic [HIST_W-1:0] hist_sel;
   logic [7:0] nb_a, nb_b, nb_c;
   logic [8:0] avg_sum;
   logic [7:0] pred;
   logic       s1_move;

   assign s1_move  = s1_valid_ff & s1_advance;
   assign mem_we   = s1_move & ~s1_report_ff;
   assign hist_sel = HIST_W'(bpp_eff - 4'd1);

   always_comb begin
      nb_a    = s1_left_ff ? left_hist_ff[hist_sel] : 8'd0;
      nb_b    = s1_first_ff ? 8'd0 : above_rd_ff;
      nb_c    = (s1_left_ff & ~s1_first_ff) ? upleft_hist_ff[hist_sel] : 8'd0;
      avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
      unique case (s1_filter_ff)
         pngu_pkg::FILT_SUB:   pred = nb_a;
         pngu_pkg::FILT_UP:    pred = nb_b;
         pngu_pkg::FILT_AVG:   pred = avg_sum[8:1];
         pngu_pkg::FILT_PAETH: pred = pngu_pkg::paeth_pick(nb_a, nb_b, nb_c);
         default:              pred = 8'd0;
      endcase
      res = s1_byte_ff + pred;
   end

   // Advance the left and above-left history on every data byte
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIXEL_BYTES_MAX; i++) begin
            left_hist_ff[i]   <= 8'd0;
            upleft_hist_ff[i] <= 8'd0;
         end
      end else if (mem_we) begin
         for (int i = PIXEL_BYTES_MAX - 1; i > 0; i--) begin
            left_hist_ff[i]   <= left_hist_ff[i-1];
            upleft_hist_ff[i] <= upleft_hist_ff[i-1];
         end
         left_hist_ff[0]   <= res;
         upleft_hist_ff[0] <= nb_b;
      end
   end

   // ---------------------------------------------------------------- output register
   logic       out_valid_in;
   logic [7:0] out_pixel_ff;
   logic       out_row_end_ff;
   logic       out_err_ff;

   assign out_valid_in = s1_move | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         if (s1_report_ff) begin
            out_pixel_ff   <= 8'd0;
            out_row_end_ff <= 1'b0;
            out_err_ff     <= 1'b1;
         end else begin
            out_pixel_ff   <= res;
            out_row_end_ff <= s1_last_ff;
            out_err_ff     <= s1_err_ff;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_byte   = out_pixel_ff;
   assign rsp_row_end      = out_row_end_ff;
   assign rsp_filter_error = out_err_ff;

   // ---------------------------------------------------------------- assertions
   a_stall_needs_s1: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with stage 1 empty");

   a_bad_filter_report: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_filter_byte && bad_filter) |=> (s1_valid_ff && s1_report_ff))
      else $error("bad filter byte did not raise an error beat");

   a_report_out: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_report_ff) |=>
         (rsp_valid && rsp_filter_error && !rsp_row_end && rsp_pixel_byte == 8'd0))
      else $error("error beat malformed at output");

   a_row_end_out: assert property (@(posedge clock) disable iff (reset)
      (s1_move && !s1_report_ff && s1_last_ff) |=> (rsp_valid && rsp_row_end))
      else $error("row end lost between stage 1 and output");

   a_row_closes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_filter_byte && last) |=> (col_ff == '0 && !first_ff))
      else $error("row did not close on its last byte");

endmodule

// ----- sim/png_scanline_unfilter_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the PNG scanline unfilter: watches the stream, result and register ports.
// Rebuilds every data byte from its own copy of the row state; depends on pngu_pkg.

module png_scanline_unfilter_checker #(
   parameter int LINE_MAX = pngu_pkg::LINE_BYTES_MAX_DEF,
   parameter int PIX_MAX  = pngu_pkg::PIXEL_BYTES_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_frame_start,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [7:0]                      rsp_pixel_byte,
   input  logic                            rsp_row_end,
   input  logic                            rsp_filter_error,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pngu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   input  logic                            pready,
   output int                              fail_count,
   output int                              pending,
   output int                              beats_checked,
   output int                              error_beats
);

   typedef struct packed {
      logic [7:0] pixel;
      logic       row_end;
      logic       err;
   } pixel_beat_type;

   pixel_beat_type  want_q[$];

   // row reconstruction state
   logic [7:0]      above_row [LINE_MAX];
   logic [7:0]      left_hist [PIX_MAX];
   logic [7:0]      upleft_hist [PIX_MAX];
   int unsigned     col_pos;
   pngu_pkg::filter_type_type cur_filter;
   logic            top_row;
   logic            bad_row;
   logic [3:0]      cfg_bpp;
   logic [13:0]     cfg_row_bytes;

   int              fails = 0;
   int              checked = 0;
   int              err_seen = 0;

   // Paeth choice: the neighbor nearest to a + b - c, ties go to a, then b
   function automatic logic [7:0] nearest_of_three(input logic [7:0] a, input logic [7:0] b,
                                                   input logic [7:0] c);
      int         est;
      int         da;
      int         db;
      int         dc;
      logic [7:0] pick;
      est = int'(a) + int'(b) - int'(c);
      da = est - int'(a);
      db = est - int'(b);
      dc = est - int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) begin
         pick = a;
      end else if (db <= dc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

   task automatic clear_model();
      int k;
      for (k = 0; k < PIX_MAX; k++) begin
         left_hist[k] = 8'h00;
         upleft_hist[k] = 8'h00;
      end
      col_pos = 0;
      cur_filter = pngu_pkg::FILT_NONE;
      top_row = 1'b1;
      bad_row = 1'b0;
      cfg_bpp = 4'd1;
      cfg_row_bytes = 14'd1;
      want_q.delete();
   endtask

   // Advance the row state by one stream byte and queue the beat it should produce
   task automatic unfilter_byte(input logic [7:0] din, input logic fs);
      int unsigned    bpp;
      int unsigned    rb;
      int unsigned    idx;
      int             k;
      logic [7:0]     a;
      logic [7:0]     b;
      logic [7:0]     c;
      logic [7:0]     pred;
      logic [7:0]     rebuilt;
      logic           at_end;
      pixel_beat_type beat;
      bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > PIX_MAX) ? PIX_MAX : cfg_bpp);
      rb = (cfg_row_bytes == 0) ? 1 : ((cfg_row_bytes > LINE_MAX) ? LINE_MAX : cfg_row_bytes);
      if (fs) begin
         top_row = 1'b1;
         col_pos = 0;
      end
      if (col_pos == 0) begin
         // filter-type byte: only a bad code yields a beat
         col_pos = 1;
         if (din > pngu_pkg::FILT_LAST_CODE) begin
            cur_filter = pngu_pkg::FILT_NONE;
            bad_row = 1'b1;
            beat.pixel = 8'h00;
            beat.row_end = 1'b0;
            beat.err = 1'b1;
            want_q.push_back(beat);
         end else begin
            cur_filter = pngu_pkg::filter_type_type'(din[2:0]);
            bad_row = 1'b0;
         end
      end else begin
         idx = col_pos - 1;
         if (idx >= LINE_MAX) idx = LINE_MAX - 1;
         a = (idx >= bpp) ? left_hist[bpp-1] : 8'h00;
         c = (idx >= bpp && !top_row) ? upleft_hist[bpp-1] : 8'h00;
         b = top_row ? 8'h00 : above_row[idx];
         case (cur_filter)
            pngu_pkg::FILT_SUB:   pred = a;
            pngu_pkg::FILT_UP:    pred = b;
            pngu_pkg::FILT_AVG:   pred = 8'(({1'b0, a} + {1'b0, b}) >> 1);
            pngu_pkg::FILT_PAETH: pred = nearest_of_three(a, b, c);
            default:              pred = 8'h00;
         endcase
         rebuilt = din + pred;
         for (k = PIX_MAX - 1; k > 0; k--) begin
            left_hist[k] = left_hist[k-1];
            upleft_hist[k] = upleft_hist[k-1];
         end
         left_hist[0] = rebuilt;
         upleft_hist[0] = b;
         above_row[idx] = rebuilt;
         at_end = (idx + 1 >= rb);
         beat.pixel = rebuilt;
         beat.row_end = at_end;
         beat.err = bad_row;
         want_q.push_back(beat);
         if (at_end) begin
            col_pos = 0;
            top_row = 1'b0;
         end else begin
            col_pos = idx + 2;
         end
      end
   endtask

   // Compare one result beat against the oldest expectation
   task automatic check_beat();
      pixel_beat_type want;
      if (want_q.size() == 0) begin
         fails++;
         if (fails <= 10)
            $display("unexpected result beat: pixel_byte %02h row_end %0b filter_error %0b",
                     rsp_pixel_byte, rsp_row_end, rsp_filter_error);
      end else begin
         want = want_q.pop_front();
         checked++;
         if (want.err) err_seen++;
         if (want.pixel !== rsp_pixel_byte || want.row_end !== rsp_row_end ||
             want.err !== rsp_filter_error) begin
            fails++;
            if (fails <= 10)
               $display("beat %0d: pixel %02h/%02h end %0b/%0b err %0b/%0b (exp/act)",
                        checked, want.pixel, rsp_pixel_byte, want.row_end, rsp_row_end,
                        want.err, rsp_filter_error);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         // track register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[2])
               pngu_pkg::CSR_IDX_BPP:       cfg_bpp = pwdata[3:0];
               pngu_pkg::CSR_IDX_ROW_BYTES: cfg_row_bytes = pwdata[13:0];
               default:                     ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_beat();
         if (req_valid && !req_stall) unfilter_byte(req_data_byte, req_frame_start);
      end
      pending <= want_q.size();
      fail_count <= fails;
      beats_checked <= checked;
      error_beats <= err_seen;
   end

endmodule

// ----- sim/png_scanline_unfilter_top_test.sv -----
`timescale 1ns / 100ps
// Testbench top for png_scanline_unfilter_top: clock, reset, stream and register stimulus.
// Depends on pngu_pkg and png_scanline_unfilter_checker, which does all result checking.

module png_scanline_unfilter_top_test;

   localparam int WATCHDOG_LIMIT = 3000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [7:0]                      req_data_byte = 8'h00;
   logic                            req_frame_start = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [7:0]                      rsp_pixel_byte;
   logic                            rsp_row_end;
   logic                            rsp_filter_error;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [pngu_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]                     pwdata = 32'h0;
   logic [31:0]                     prdata;
   logic                            pready;

   int                    fail_count;
   int                    pending;
   int                    beats_checked;
   int                    error_beats;

   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    hold_asks = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    quiet_cycles = 0;
   int                    rows_len = 1;
   int                    bytes_sent = 0;
   int                    settings_run = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   png_scanline_unfilter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_byte   (rsp_pixel_byte),
      .rsp_row_end      (rsp_row_end),
      .rsp_filter_error (rsp_filter_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   png_scanline_unfilter_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_byte   (rsp_pixel_byte),
      .rsp_row_end      (rsp_row_end),
      .rsp_filter_error (rsp_filter_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .fail_count       (fail_count),
      .pending          (pending),
      .beats_checked    (beats_checked),
      .error_beats      (error_beats)
   );

   // Result side: random stall, or a long hold when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= 90;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Abort when no beat or register access moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[png_scanline_unfilter_top] ERROR");
            $finish;
         end
      end
   end

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one stream beat, with an optional gap first; hold it until taken
   task automatic push_beat(input logic [7:0] value, input logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Drop valid and wait until every expected beat has come back
   task automatic drain_stream(input int settle);
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_filter();
      logic [7:0] code;
      if ($urandom_range(99) < 92) code = 8'($urandom_range(pngu_pkg::FILT_LAST_CODE));
      else code = 8'($urandom_range(255, pngu_pkg::FILT_LAST_CODE + 1));
      return code;
   endfunction

   function automatic logic [7:0] pick_data();
      int         r;
      logic [7:0] value;
      r = $urandom_range(99);
      if (r < 8) value = 8'h00;
      else if (r < 16) value = 8'hFF;
      else if (r < 30) value = 8'($urandom_range(3)) << 6;
      else value = 8'($urandom_range(255));
      return value;
   endfunction

   // One row: filter byte, then data bytes; a rare frame start restarts the row
   task automatic send_row(input logic new_frame, input int noise_pm);
      int col;
      push_beat(pick_filter(), new_frame);
      col = 0;
      while (col < rows_len) begin
         if ($urandom_range(999) < noise_pm) begin
            push_beat(pick_filter(), 1'b1);
            col = 0;
         end else begin
            push_beat(pick_data(), 1'b0);
            col++;
         end
      end
   endtask

   // Program a setting while idle, then stream rows under it
   task automatic run_phase(input logic [31:0] bpp_val, input logic [31:0] rb_val,
                            input int n_items, input int frame_pct, input int noise_pm,
                            input logic squeeze);
      int   start_count;
      logic paused;
      drain_stream(8);
      csr_write(pngu_pkg::CSR_IDX_BPP, bpp_val);
      csr_write(pngu_pkg::CSR_IDX_ROW_BYTES, rb_val);
      rows_len = (rb_val[13:0] == 0) ? 1 :
                 ((rb_val[13:0] > pngu_pkg::LINE_BYTES_MAX_DEF) ?
                  pngu_pkg::LINE_BYTES_MAX_DEF : rb_val[13:0]);
      settings_run++;
      start_count = bytes_sent;
      paused = 1'b0;
      if (squeeze) hold_asks <= hold_asks + 1;
      // first row of every setting opens a frame, so no unwritten line entry is read
      send_row(1'b1, noise_pm);
      while (bytes_sent - start_count < n_items) begin
         if (squeeze && !paused && bytes_sent - start_count >= n_items / 2) begin
            drain_stream(0);
            paused = 1'b1;
         end
         send_row($urandom_range(99) < frame_pct, noise_pm);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: one byte of left distance, two data bytes per row
      set_idling(11, 67);
      csr_write(pngu_pkg::CSR_IDX_BPP, 32'd1);
      csr_write(pngu_pkg::CSR_IDX_ROW_BYTES, 32'd2);
      rows_len = 2;
      settings_run++;
      // no frame start: the first row after reset still has nothing above it
      push_beat(pngu_pkg::FILT_NONE, 1'b0);  push_beat(8'h00, 1'b0); push_beat(8'hFF, 1'b0);
      push_beat(pngu_pkg::FILT_SUB, 1'b0);   push_beat(8'hFF, 1'b0); push_beat(8'h01, 1'b0);
      push_beat(pngu_pkg::FILT_UP, 1'b0);    push_beat(8'h80, 1'b0); push_beat(8'h80, 1'b0);
      push_beat(pngu_pkg::FILT_AVG, 1'b0);   push_beat(8'hFF, 1'b0); push_beat(8'hFF, 1'b0);
      push_beat(pngu_pkg::FILT_PAETH, 1'b0); push_beat(8'h10, 1'b0); push_beat(8'hF0, 1'b0);
      // bad filter codes at both ends of the invalid range
      push_beat(pngu_pkg::FILT_LAST_CODE + 8'd1, 1'b0);
      push_beat(8'hAA, 1'b0); push_beat(8'h55, 1'b0);
      push_beat(8'hFF, 1'b0); push_beat(8'h00, 1'b0); push_beat(8'hFF, 1'b0);
      // frame start in the middle of a row abandons it
      push_beat(pngu_pkg::FILT_PAETH, 1'b1); push_beat(8'h7F, 1'b0);
      push_beat(pngu_pkg::FILT_UP, 1'b1);    push_beat(8'h01, 1'b0); push_beat(8'h02, 1'b0);

      // random rows, sender idling lightly and receiver heavily
      run_phase(32'd3, 32'd7, 120, 10, 5, 1'b0);
      run_phase(32'd8, 32'd20, 120, 10, 5, 1'b0);
      run_phase(32'd0, 32'd0, 60, 10, 5, 1'b0);

      // sender idling heavily, receiver lightly
      set_idling(67, 11);
      run_phase(32'd15, 32'd5, 100, 10, 5, 1'b0);
      run_phase(32'd4, 32'd64, 160, 10, 5, 1'b0);
      run_phase(32'd1, 32'd1, 60, 10, 5, 1'b0);
      run_phase($urandom_range(1, 8), $urandom_range(1, 100), 120, 10, 5, 1'b0);

      // no idling; long receiver hold and a mid-stream drain, then two long rows
      set_idling(0, 0);
      run_phase(32'd6, 32'd33, 160, 10, 5, 1'b1);
      run_phase(32'd2, 32'd300, 2 * (300 + 1), 0, 0, 1'b0);

      drain_stream(8);
      $display("Streamed %0d bytes over %0d settings; %0d beats compared, %0d on bad-filter rows.",
               bytes_sent, settings_run, beats_checked, error_beats);
      $display("Mixed sender and receiver idling, one long receiver hold and one drain.");
      if (fail_count == 0 && pending == 0) begin
         $display("[png_scanline_unfilter_top] OK");
      end else begin
         $display("[png_scanline_unfilter_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/pngu_pkg.sv
src/png_scanline_unfilter_top.sv
sim/png_scanline_unfilter_checker.sv
sim/png_scanline_unfilter_top_test.sv
